// ===== rtl/voxel_hash_point_dedup_core_defines.svh =====
// Assertion macros used by the dedup core RTL file.
`ifndef VOXEL_HASH_POINT_DEDUP_CORE_DEFINES_SVH
`define VOXEL_HASH_POINT_DEDUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define VHPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VHPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VHPD_ASSERT(lbl, clk, rst, prop, msg)
`define VHPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/vhpd_pkg.sv =====
package vhpd_pkg;

  localparam int TABLE_ENTRIES_DEF = 8192;
  localparam int MAX_PROBES_DEF    = 16;

  localparam logic [63:0] HASH_SEED  = 64'd1469598103934665603;
  localparam logic [63:0] HASH_GOLD  = 64'h9e3779b97f4a7c15;

  localparam int EPOCH_W = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_RECIP    = 2'd1;

  localparam logic [31:0] LEAF_RECIP_RESET = 32'd1310720;

  typedef enum logic [1:0] {
    H_IDLE,
    H_QUANT,
    H_FOLD,
    H_MUL
  } hash_state_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK
  } ctl_state_t;

  typedef struct packed {
    logic        done;
    logic [63:0] key;
  } hash_res_t;

endpackage

// ===== rtl/voxel_hash_point_dedup_core.sv =====
// Filter off: the result strobe comes in the cycle after start, unless a clearing pass runs
// first. Filter on: the lookup runs the hash, then a read and a check of the table RAM per probe.
// With the filter on, busy stays high until the item is finished; with it off, busy stays low outside a clearing pass.
// Results cannot be stalled: done is a one-cycle strobe.
// Reset (synchronous rst) and every 15th frame_start run a clearing pass over
// every entry of the table RAM with busy high.
`include "voxel_hash_point_dedup_core_defines.svh"

module voxel_hash_point_dedup_core #(
  parameter int TABLE_ENTRIES = vhpd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_PROBES    = vhpd_pkg::MAX_PROBES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vhpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          frame_start,
  input  logic [31:0]                   x_pos,
  input  logic [31:0]                   y_pos,
  input  logic [31:0]                   z_pos,
  input  logic [31:0]                   intensity_bits,
  input  logic [15:0]                   ring_index,
  input  logic [31:0]                   time_bits,
  output logic                          done,
  output logic [31:0]                   out_x,
  output logic [31:0]                   out_y,
  output logic [31:0]                   out_z,
  output logic [31:0]                   out_intensity,
  output logic [15:0]                   out_ring,
  output logic [31:0]                   out_time,
  output logic                          table_overflow
);
  import vhpd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int PW    = $clog2(MAX_PROBES + 1);
  localparam int RAM_W = 64 + EPOCH_W;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  ctl_state_t state, state_next;

  logic              filter_enable;
  logic [31:0]       leaf_recip;
  logic [EPOCH_W-1:0] epoch;
  logic              pending;
  logic [IDX_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]  slot;
  logic [PW-1:0]     probe_cnt;

  logic [31:0] item_x, item_y, item_z, item_int, item_time;
  logic [15:0] item_ring;

  logic              accept, wrap_clear, clr_last, last_probe;
  logic              tag_hit, key_hit;
  logic              hash_go;
  hash_res_t         hres;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic              done_next, ovf_next;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign wrap_clear = frame_start && (epoch == EPOCH_MAX);
  assign clr_last   = (clr_cnt == {IDX_W{1'b1}});
  assign last_probe = (probe_cnt == PW'(MAX_PROBES - 1));
  assign tag_hit    = (ram_rdata[RAM_W-1:64] == epoch);
  assign key_hit    = (ram_rdata[63:0] == hres.key);

  vhpd_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .go         (hash_go),
    .x_pos      (item_x),
    .y_pos      (item_y),
    .z_pos      (item_z),
    .leaf_recip (leaf_recip),
    .res        (hres)
  );

  vhpd_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = (pending && filter_enable) ? ST_HASH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (wrap_clear) state_next = ST_CLEAR;
          else if (filter_enable) state_next = ST_HASH;
        end
      end
      ST_HASH:  if (hres.done) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (!tag_hit || key_hit || last_probe) state_next = ST_IDLE;
        else state_next = ST_READ;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    hash_go   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = {epoch, hres.key};
    done_next = 1'b0;
    ovf_next  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_last && pending) begin
          hash_go   = filter_enable;
          done_next = !filter_enable;
        end
      end
      ST_IDLE: begin
        if (accept && !wrap_clear) begin
          hash_go   = filter_enable;
          done_next = !filter_enable;
        end
      end
      ST_CHECK: begin
        if (!tag_hit) begin
          ram_we    = 1'b1;
          done_next = 1'b1;
        end else if (!key_hit && last_probe) begin
          done_next = 1'b1;
          ovf_next  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      filter_enable <= 1'b0;
      leaf_recip    <= LEAF_RECIP_RESET;
      epoch         <= EPOCH_ONE;
      pending       <= 1'b0;
      clr_cnt       <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
          CFG_LEAF_RECIP:    leaf_recip    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
        if (clr_last) pending <= 1'b0;
      end
      if (accept) begin
        pending <= wrap_clear;
        if (frame_start) begin
          epoch <= wrap_clear ? EPOCH_ONE : epoch + EPOCH_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_x    <= x_pos;
      item_y    <= y_pos;
      item_z    <= z_pos;
      item_int  <= intensity_bits;
      item_ring <= ring_index;
      item_time <= time_bits;
    end
    if (done_next) begin
      table_overflow <= ovf_next;
    end
    if (state == ST_HASH && hres.done) begin
      slot      <= hres.key[IDX_W-1:0];
      probe_cnt <= '0;
    end else if (state == ST_CHECK) begin
      slot      <= slot + IDX_W'(1);
      probe_cnt <= probe_cnt + PW'(1);
    end
  end

  assign out_x         = item_x;
  assign out_y         = item_y;
  assign out_z         = item_z;
  assign out_intensity = item_int;
  assign out_ring      = item_ring;
  assign out_time      = item_time;

  `VHPD_ASSERT(a_epoch_nonzero, clk, rst, epoch != '0, "epoch tag reached zero")
  `VHPD_ASSERT(a_hash_done_in_hash, clk, rst, hres.done |-> state == ST_HASH, "hash done outside hash state")
  `VHPD_ASSERT(a_probe_bound, clk, rst, state == ST_CHECK |-> probe_cnt < PW'(MAX_PROBES), "probe count past limit")

endmodule

// ===== rtl/vhpd_ram.sv =====
module vhpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/vhpd_hash.sv =====
module vhpd_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [31:0]         x_pos,
  input  logic [31:0]         y_pos,
  input  logic [31:0]         z_pos,
  input  logic [31:0]         leaf_recip,
  output vhpd_pkg::hash_res_t res
);
  import vhpd_pkg::*;

  hash_state_t state, state_next;
  logic [1:0]  cidx;
  logic [31:0] coord;
  logic signed [63:0] prod;
  logic signed [63:0] op_a, op_b;
  logic [63:0] h, t, v;
  logic        done;

  always_comb begin
    unique case (cidx)
      2'd0:    coord = x_pos;
      2'd1:    coord = y_pos;
      default: coord = z_pos;
    endcase
  end

  assign op_a = {{32{coord[31]}}, coord};
  assign op_b = {32'b0, leaf_recip};
  assign v    = {{32{prod[63]}}, prod[63:32]};

  always_comb begin
    state_next = state;
    unique case (state)
      H_IDLE:  if (go) state_next = H_QUANT;
      H_QUANT: state_next = H_FOLD;
      H_FOLD:  state_next = H_MUL;
      H_MUL:   state_next = (cidx == 2'd2) ? H_IDLE : H_QUANT;
      default: state_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      cidx  <= 2'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == H_MUL) && (cidx == 2'd2);
      if (state == H_IDLE && go) begin
        cidx <= 2'd0;
      end else if (state == H_MUL) begin
        cidx <= cidx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == H_IDLE && go) begin
      h <= HASH_SEED;
    end
    if (state == H_QUANT) begin
      prod <= op_a * op_b;
    end
    if (state == H_FOLD) begin
      t <= h ^ (v + HASH_GOLD + (h << 6) + (h >> 2));
    end
    if (state == H_MUL) begin
      h <= (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
    end
  end

  assign res.done = done;
  assign res.key  = h;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import vhpd_pkg::*;

  localparam int          SLOTS      = 8192;
  localparam int          PROBE_MAX  = 16;
  localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 60;

  typedef enum logic { R_ITEM, R_CFG } row_kind_t;
  typedef enum logic [1:0] { CHK_MODEL, CHK_PASS, CHK_DROP } row_chk_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  fs;
    logic [31:0]           x, y, z, inten;
    logic [15:0]           ring;
    logic [31:0]           tm;
    row_chk_t              chk;
  } row_t;

  typedef struct packed {
    logic [31:0] x, y, z, inten;
    logic [15:0] ring;
    logic [31:0] tm;
    logic        ovf;
  } point_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FILTER_ENABLE;
  logic [31:0] cfg_data = 0;
  logic start = 0;
  logic busy;
  logic frame_start = 0;
  logic [31:0] x_pos = 0, y_pos = 0, z_pos = 0, intensity_bits = 0, time_bits = 0;
  logic [15:0] ring_index = 0;
  logic done;
  logic [31:0] out_x, out_y, out_z, out_intensity, out_time;
  logic [15:0] out_ring;
  logic table_overflow;

  voxel_hash_point_dedup_core u_top (.*);

  always #1 clk = ~clk;

  logic        m_enable;
  logic [31:0] m_leaf_recip;
  logic [63:0] m_keys [SLOTS];
  bit          m_used [SLOTS];
  point_t      kept_q [$];
  row_t        rows [$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  logic [31:0] pool [16];

  function automatic logic [63:0] voxel_of(logic [31:0] c);
    logic signed [63:0] prod;
    prod = $signed({{32{c[31]}}, c}) * $signed({32'b0, m_leaf_recip});
    return prod >>> 32;
  endfunction

  function automatic logic [63:0] voxel_key(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [63:0] h;
    logic [63:0] v [3];
    v[0] = voxel_of(x);
    v[1] = voxel_of(y);
    v[2] = voxel_of(z);
    h = HASH_SEED;
    for (int i = 0; i < 3; i++) begin
      h = h ^ (v[i] + HASH_GOLD + (h << 6) + (h >> 2));
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  // returns 1 when the point is kept
  function automatic bit dedup_point(logic fs, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z, output logic ovf);
    logic [63:0] key;
    int slot;
    ovf = 0;
    if (fs) foreach (m_used[i]) m_used[i] = 0;
    if (!m_enable) return 1;
    key = voxel_key(x, y, z);
    slot = int'(key % SLOTS);
    for (int p = 0; p < PROBE_MAX; p++) begin
      if (!m_used[slot]) begin
        m_used[slot] = 1;
        m_keys[slot] = key;
        return 1;
      end
      if (m_keys[slot] == key) return 0;
      slot = (slot + 1) % SLOTS;
    end
    ovf = 1;
    return 1;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  always @(posedge clk) begin
    point_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (!rst && done) begin
      if (kept_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item x=%h y=%h z=%h", out_x, out_y, out_z);
      end else begin
        want = kept_q.pop_front();
        if (want != {out_x, out_y, out_z, out_intensity, out_ring, out_time,
                     table_overflow}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp x=%h y=%h z=%h i=%h r=%h t=%h o=%b / got %h %h %h %h %h %h %b",
                     want.x, want.y, want.z, want.inten, want.ring, want.tm, want.ovf,
                     out_x, out_y, out_z, out_intensity, out_ring, out_time,
                     table_overflow);
        end
      end
    end
  end

  task automatic wait_quiet();
    while (kept_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    wait_quiet();
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx == CFG_FILTER_ENABLE) m_enable = data[0];
    else if (idx == CFG_LEAF_RECIP) m_leaf_recip = data;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_point(logic fs, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] inten, logic [15:0] ring, logic [31:0] tm,
                            row_chk_t chk);
    logic ovf;
    bit keep;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    frame_start = fs;
    x_pos = x; y_pos = y; z_pos = z;
    intensity_bits = inten; ring_index = ring; time_bits = tm;
    @(posedge clk);
    while (busy) @(posedge clk);
    keep = dedup_point(fs, x, y, z, ovf);
    if (chk == CHK_PASS) begin
      keep = 1;
      ovf = 0;
    end else if (chk == CHK_DROP) begin
      keep = 0;
    end
    if (keep) kept_q.insert(kept_q.size(), '{x, y, z, inten, ring, tm, ovf});
    @(negedge clk);
    start = 0;
  endtask

  function automatic row_t pt(logic fs, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              row_chk_t chk);
    return '{R_ITEM, CFG_FILTER_ENABLE, fs, x, y, z, $urandom, 16'($urandom), $urandom, chk};
  endfunction

  function automatic row_t cf(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    return '{R_CFG, idx, 1'b0, data, 0, 0, 0, 0, 0, CHK_MODEL};
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 1)) return pool[$urandom_range(0, 15)] + $urandom_range(0, 255);
    return $urandom;
  endfunction

  initial begin
    logic [31:0] cx, cy, cz;
    int span;

    m_enable = 0;
    m_leaf_recip = LEAF_RECIP_RESET;
    foreach (m_used[i]) m_used[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    wait_quiet();

    add_row('{R_ITEM, CFG_FILTER_ENABLE, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
              32'hffff_ffff, 16'hffff, 32'h0, CHK_PASS});
    add_row('{R_ITEM, CFG_FILTER_ENABLE, 1'b1, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 32'h0, 16'h0, 32'hffff_ffff, CHK_PASS});
    add_row(cf(CFG_SPARE_A, 32'hffff_ffff));
    add_row(cf(CFG_SPARE_B, 32'h0));
    add_row(pt(0, 0, 0, 0, CHK_PASS));
    add_row(cf(CFG_FILTER_ENABLE, 1));
    add_row(pt(1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, CHK_PASS));
    add_row(pt(0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, CHK_DROP));
    add_row(pt(0, 32'h0001_0100, 32'h0002_0000, 32'h0003_0000, CHK_MODEL));
    add_row(pt(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, CHK_MODEL));
    add_row(pt(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, CHK_MODEL));
    add_row(pt(0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, CHK_MODEL));
    add_row(pt(0, 0, 0, 0, CHK_MODEL));
    add_row(pt(1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, CHK_PASS));
    add_row(cf(CFG_LEAF_RECIP, 0));
    add_row(pt(1, 32'h1234_5678, 32'h8765_4321, 32'h0bad_f00d, CHK_PASS));
    add_row(pt(0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, CHK_DROP));
    add_row(cf(CFG_LEAF_RECIP, 32'hffff_ffff));
    add_row(pt(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, CHK_MODEL));
    add_row(pt(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, CHK_MODEL));
    add_row(pt(0, 1, 1, 1, CHK_MODEL));
    add_row(pt(0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, CHK_MODEL));
    add_row(cf(CFG_FILTER_ENABLE, 0));
    add_row(pt(0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, CHK_PASS));

    foreach (rows[i]) begin
      if (rows[i].kind == R_CFG) write_reg(rows[i].idx, rows[i].x);
      else send_point(rows[i].fs, rows[i].x, rows[i].y, rows[i].z, rows[i].inten,
                      rows[i].ring, rows[i].tm, rows[i].chk);
    end

    // crowd keys into the four slots around the table end to force probe overflow and wrap
    write_reg(CFG_FILTER_ENABLE, 1);
    write_reg(CFG_LEAF_RECIP, 32'hffff_ffff);
    for (int n = 0; n < 22; n++) begin
      do begin
        cx = $urandom; cy = $urandom; cz = $urandom;
        span = (int'(voxel_key(cx, cy, cz) % SLOTS) + 2) % SLOTS;
      end while (span >= 4);
      send_point(n == 0, cx, cy, cz, $urandom, 16'($urandom), $urandom, CHK_MODEL);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          write_reg(CFG_LEAF_RECIP, LEAF_RECIP_RESET);
        end
        1: begin
          idle_pct = 84;
          write_reg(CFG_LEAF_RECIP, $urandom_range(1, 32'h0010_0000));
        end
        2: begin
          idle_pct = 14;
          write_reg(CFG_LEAF_RECIP, 1);
        end
        3: begin
          idle_pct = 0;
          write_reg(CFG_FILTER_ENABLE, 0);
        end
        default: begin
          idle_pct = 0;
          write_reg(CFG_FILTER_ENABLE, 1);
          write_reg(CFG_LEAF_RECIP, $urandom);
        end
      endcase
      foreach (pool[i]) pool[i] = $urandom;
      for (int n = 0; n < 340; n++)
        send_point($urandom_range(0, 39) == 0, rand_coord(), rand_coord(), rand_coord(),
                   $urandom, 16'($urandom), $urandom, CHK_MODEL);
    end

    wait_quiet();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
